// ----- rtl/core/ssd_pkg.sv -----
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants of the seven-segment scan driver
// Field widths, item kinds, register indexes, the segment decoder and the
// structs that travel between the conversion pipe, the scan core and the queue.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Digit count of the display
  localparam int unsigned DIGITS_DEF = 6;
  localparam int unsigned DIGITS_MAX = 8;

  // Field widths
  localparam int unsigned VALUE_W = 24;
  localparam int unsigned DOTS_W  = 6;
  localparam int unsigned DUR_W   = 8;
  localparam int unsigned TPS_W   = 16;
  localparam int unsigned LIMIT_W = 24;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned PAIR_W  = 7;
  localparam int unsigned IN_DATA_W = 40;

  // Configuration register reset values
  localparam logic             TIME_FORMAT_RST = 1'b1;
  localparam logic [TPS_W-1:0] TPS_RST         = 16'd1000;

  // Item kind carried in tuser of the input stream
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  // Configuration register indexes
  typedef enum logic {
    REG_TIME_FORMAT      = 1'b0,
    REG_TICKS_PER_SECOND = 1'b1
  } cfg_reg_e;

  // Control fields that ride along the conversion pipe
  typedef struct packed {
    kind_e               kind;
    logic [DOTS_W-1:0]   dots;
    logic [LIMIT_W-1:0]  limit;
  } ctl_t;

  // Four two-digit groups, least significant group first
  typedef logic [3:0][PAIR_W-1:0] pairs_t;

  // Last stage of the conversion pipe
  typedef struct packed {
    logic   valid;
    ctl_t   ctl;
    pairs_t pairs;
  } conv_t;

  // One result item
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              fin;
    logic              last;
  } res_t;

  // Up to two results pushed in one cycle
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  // Segment pattern of one decimal digit, blanks fall back to zero
  function automatic logic [6:0] seg_code(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h27;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h3F;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/ssd_conv.sv -----
// ----------------------------------------------------------------------------
// ssd_conv: value to decimal conversion pipe
// Turns the loaded value into hhmmss (time mode) or keeps it (raw mode), then
// splits it into four two-digit groups. Tick items ride along unchanged.
// ----------------------------------------------------------------------------
module ssd_conv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       in_valid_i,
  input  ssd_pkg::kind_e             kind_i,
  input  logic [ssd_pkg::VALUE_W-1:0] value_i,
  input  logic [ssd_pkg::DOTS_W-1:0] dots_i,
  input  logic [ssd_pkg::DUR_W-1:0]  dur_i,
  input  logic                       time_format_i,
  input  logic [ssd_pkg::TPS_W-1:0]  tps_i,
  output ssd_pkg::conv_t             out_o
);
  import ssd_pkg::*;

  localparam int unsigned STAGES     = 9;
  localparam int unsigned HOUR_SECS  = 3600;
  localparam int unsigned MIN_SECS   = 60;
  localparam int unsigned TEN_K      = 10000;
  localparam int unsigned HUNDRED    = 100;
  // Reciprocals for hours, minutes, 10000 rounded down: exact or one low
  localparam logic [24:0] HOUR_RECIP = 25'd19088743;  // 2^36 / 3600
  localparam int unsigned HOUR_SHIFT = 36;
  localparam logic [12:0] MIN_RECIP  = 13'd4369;      // 2^18 / 60
  localparam int unsigned MIN_SHIFT  = 18;
  localparam logic [26:0] TENK_RECIP = 27'd109951162; // 2^40 / 10000
  localparam int unsigned TENK_SHIFT = 40;
  localparam logic [12:0] HUND_RECIP = 13'd5243;      // exact for x < 10000
  localparam int unsigned HUND_SHIFT = 19;

  logic [STAGES-1:0] vld_q;

  // Stage 1: input register
  kind_e              kind1_q;
  logic [VALUE_W-1:0] val1_q;
  logic [DOTS_W-1:0]  dots1_q;
  logic [DUR_W-1:0]   dur1_q;

  // Stage 2: hour estimate, tick limit
  ctl_t               ctl2_q;
  logic [VALUE_W-1:0] val2_q;
  logic [12:0]        hq2_q, hq2_d;
  logic [48:0]        hprod;

  // Stage 3: remainder of the hour estimate
  ctl_t               ctl3_q;
  logic [VALUE_W-1:0] val3_q;
  logic [12:0]        hq3_q;
  logic [12:0]        rem3_q, rem3_d;
  logic [24:0]        hback;

  // Stage 4: corrected hour, minute estimate
  ctl_t               ctl4_q;
  logic [VALUE_W-1:0] val4_q;
  logic [12:0]        hour4_q, hour4_d;
  logic [11:0]        rem4_q, rem4_d;
  logic [5:0]         mq4_q, mq4_d;
  logic [24:0]        mprod;

  // Stage 5: corrected minute and second
  ctl_t               ctl5_q;
  logic [VALUE_W-1:0] val5_q;
  logic [12:0]        hour5_q;
  logic [5:0]         min5_q, min5_d;
  logic [5:0]         sec5_q, sec5_d;
  logic [11:0]        sec_raw;

  // Stage 6: number to show
  ctl_t               ctl6_q;
  logic [25:0]        num6_q, num6_d;

  // Stage 7: upper four digits estimate
  ctl_t               ctl7_q;
  logic [25:0]        num7_q;
  logic [12:0]        aq7_q, aq7_d;
  logic [52:0]        kprod;

  // Stage 8: upper and lower four-digit halves
  ctl_t               ctl8_q;
  logic [12:0]        hi8_q, hi8_d;
  logic [13:0]        lo8_q, lo8_d;
  logic [26:0]        lo_raw;

  // Stage 9: two-digit groups
  ctl_t               ctl9_q;
  pairs_t             pairs9_q, pairs9_d;

  // Shift item valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[STAGES-2:0], in_valid_i};
    end
  end

  // Hour estimate by reciprocal
  always_comb begin
    hprod = 49'(val1_q) * 49'(HOUR_RECIP);
    hq2_d = hprod[HOUR_SHIFT +: 13];
  end

  // Remainder after hour estimate
  always_comb begin
    hback  = 25'(val2_q) - 25'(hq2_q) * 25'(HOUR_SECS);
    rem3_d = hback[12:0];
  end

  // Correct hour, estimate minutes
  always_comb begin
    if (rem3_q >= 13'(HOUR_SECS)) begin
      hour4_d = hq3_q + 13'd1;
      rem4_d  = 12'(rem3_q - 13'(HOUR_SECS));
    end else begin
      hour4_d = hq3_q;
      rem4_d  = rem3_q[11:0];
    end
    mprod = 25'(rem4_d) * 25'(MIN_RECIP);
    mq4_d = mprod[MIN_SHIFT +: 6];
  end

  // Correct minutes, derive seconds
  always_comb begin
    sec_raw = rem4_q - 12'(mq4_q) * 12'(MIN_SECS);
    if (sec_raw >= 12'(MIN_SECS)) begin
      min5_d = mq4_q + 6'd1;
      sec5_d = 6'(sec_raw - 12'(MIN_SECS));
    end else begin
      min5_d = mq4_q;
      sec5_d = sec_raw[5:0];
    end
  end

  // Pack hhmmss or pass the raw value
  always_comb begin
    if (time_format_i) begin
      num6_d = 26'(hour5_q) * 26'(TEN_K) + 26'(min5_q) * 26'(HUNDRED) + 26'(sec5_q);
    end else begin
      num6_d = 26'(val5_q);
    end
  end

  // Estimate upper four digits
  always_comb begin
    kprod = 53'(num6_q) * 53'(TENK_RECIP);
    aq7_d = kprod[TENK_SHIFT +: 13];
  end

  // Correct the split into halves
  always_comb begin
    lo_raw = 27'(num7_q) - 27'(aq7_q) * 27'(TEN_K);
    if (lo_raw >= 27'(TEN_K)) begin
      hi8_d = aq7_q + 13'd1;
      lo8_d = 14'(lo_raw - 27'(TEN_K));
    end else begin
      hi8_d = aq7_q;
      lo8_d = lo_raw[13:0];
    end
  end

  // Split each half into two-digit groups
  always_comb begin
    logic [13:0] x [2];
    logic [26:0] p;
    logic [PAIR_W-1:0] hq;
    x[0] = lo8_q;
    x[1] = 14'(hi8_q);
    for (int unsigned h = 0; h < 2; h++) begin
      p  = 27'(x[h]) * 27'(HUND_RECIP);
      hq = p[HUND_SHIFT +: PAIR_W];
      pairs9_d[2*h]   = PAIR_W'(x[h] - 14'(hq) * 14'(HUNDRED));
      pairs9_d[2*h+1] = hq;
    end
  end

  // Stage registers, advanced together
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kind1_q  <= kind_i;
      val1_q   <= value_i;
      dots1_q  <= dots_i;
      dur1_q   <= dur_i;

      ctl2_q   <= '{kind: kind1_q, dots: dots1_q, limit: LIMIT_W'(dur1_q) * LIMIT_W'(tps_i)};
      val2_q   <= val1_q;
      hq2_q    <= hq2_d;

      ctl3_q   <= ctl2_q;
      val3_q   <= val2_q;
      hq3_q    <= hq2_q;
      rem3_q   <= rem3_d;

      ctl4_q   <= ctl3_q;
      val4_q   <= val3_q;
      hour4_q  <= hour4_d;
      rem4_q   <= rem4_d;
      mq4_q    <= mq4_d;

      ctl5_q   <= ctl4_q;
      val5_q   <= val4_q;
      hour5_q  <= hour4_q;
      min5_q   <= min5_d;
      sec5_q   <= sec5_d;

      ctl6_q   <= ctl5_q;
      num6_q   <= num6_d;

      ctl7_q   <= ctl6_q;
      num7_q   <= num6_q;
      aq7_q    <= aq7_d;

      ctl8_q   <= ctl7_q;
      hi8_q    <= hi8_d;
      lo8_q    <= lo8_d;

      ctl9_q   <= ctl8_q;
      pairs9_q <= pairs9_d;
    end
  end

  assign out_o = '{valid: vld_q[STAGES-1], ctl: ctl9_q, pairs: pairs9_q};

endmodule

// ----- rtl/core/ssd_scan.sv -----
// ----------------------------------------------------------------------------
// ssd_scan: digit store and scan sequencer
// Commits the item leaving the conversion pipe: a load fills the store and
// restarts the scan, a tick on a lit display drives a digit and may close it.
// ----------------------------------------------------------------------------
module ssd_scan #(
  parameter int unsigned DIGITS = ssd_pkg::DIGITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  ssd_pkg::conv_t conv_i,
  output ssd_pkg::push_t push_o
);
  import ssd_pkg::*;

  localparam int unsigned IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic [3:0]         store_q [DIGITS];
  logic [DOTS_W-1:0]  dots_q;
  logic [IDX_W-1:0]   idx_q;
  logic [LIMIT_W-1:0] cnt_q;
  logic [LIMIT_W-1:0] lim_q;
  logic               active_q;

  logic               commit;
  logic               tick_fire;
  logic [3:0]         dec [DIGITS_MAX];
  logic [2:0]         idx3;
  logic [7:0]         sel;
  logic [7:0]         dots_ext;
  logic [LIMIT_W-1:0] cnt_nxt;
  logic               done;
  logic [WORD_W-1:0]  word;

  assign commit    = adv_i && conv_i.valid;
  assign tick_fire = commit && (conv_i.ctl.kind == KIND_TICK) && active_q;

  // Break each two-digit group into decimal digits, least significant first
  always_comb begin
    logic [14:0] p;
    logic [3:0]  t;
    for (int unsigned k = 0; k < 4; k++) begin
      p            = 15'(conv_i.pairs[k]) * 15'd205;
      t            = p[14:11];
      dec[2*k+1]   = t;
      dec[2*k]     = 4'(conv_i.pairs[k] - 7'(t) * 7'd10);
    end
  end

  // Build the drive word of the current digit
  always_comb begin
    idx3     = 3'(idx_q);
    sel      = ~(8'd1 << idx3);
    dots_ext = 8'(dots_q);
    word     = {sel, dots_ext[idx3], seg_code(store_q[idx_q])};
    cnt_nxt  = cnt_q + LIMIT_W'(1);
    done     = cnt_nxt > lim_q;
  end

  // Hold display state, restart on load, advance on tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < DIGITS; i++) begin
        store_q[i] <= '0;
      end
      dots_q   <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
      lim_q    <= '0;
      active_q <= 1'b0;
    end else if (commit && conv_i.ctl.kind == KIND_LOAD) begin
      for (int unsigned i = 0; i < DIGITS; i++) begin
        store_q[i] <= dec[DIGITS-1-i];
      end
      dots_q   <= conv_i.ctl.dots;
      lim_q    <= conv_i.ctl.limit;
      cnt_q    <= '0;
      idx_q    <= '0;
      active_q <= 1'b1;
    end else if (tick_fire) begin
      idx_q    <= (idx_q == IDX_W'(DIGITS - 1)) ? '0 : idx_q + IDX_W'(1);
      cnt_q    <= cnt_nxt;
      if (done) begin
        active_q <= 1'b0;
      end
    end
  end

  // Digit word, then the blank word when the display closes
  assign push_o = '{v0: tick_fire,
                    v1: tick_fire && done,
                    r0: '{word: word, fin: 1'b0, last: !done},
                    r1: '{word: '0, fin: 1'b1, last: 1'b1}};

endmodule

// ----- rtl/core/ssd_outq.sv -----
// ----------------------------------------------------------------------------
// ssd_outq: result queue
// Four-entry queue that takes up to two result items per cycle, hands them
// out one per ready cycle and stalls the pipe when it lacks two free slots.
// ----------------------------------------------------------------------------
module ssd_outq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ssd_pkg::push_t              push_i,
  output logic                        room_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [ssd_pkg::WORD_W-1:0]  m_axis_tdata,
  output logic                        m_axis_tuser,
  output logic                        m_axis_tlast
);
  import ssd_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  res_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  res_t             head;

  assign pop  = m_axis_tvalid && m_axis_tready;
  assign head = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + CNT_W'(push_i.v0) + CNT_W'(push_i.v1) - CNT_W'(pop);
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PTR_W'(push_i.v0) + PTR_W'(push_i.v1);
      rd_q  <= rd_q + PTR_W'(pop);
      cnt_q <= cnt_d;
    end
  end

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr_q + PTR_W'(1)] <= push_i.r1;
    end
  end

  assign room_o        = cnt_q <= CNT_W'(DEPTH - 2);
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = head.word;
  assign m_axis_tuser  = head.fin;
  assign m_axis_tlast  = head.last;

endmodule

// ----- rtl/core/seven_segment_scan_driver_unit.sv -----
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_unit: multiplexed seven-segment scan driver
// Top level: configuration registers, conversion pipe, scan core and queue.
// ----------------------------------------------------------------------------
// Takes one item per cycle (load or tick) whenever the four-entry result
// queue has two free slots; with the output side ready it stalls only when
// closing ticks, which emit two words each, come close together. Each
// item passes a nine-stage conversion pipe and is committed at its end, where
// a tick's drive word enters the result queue. A load computes hhmmss (time
// mode) and the two-digit groups inside that pipe and emits nothing; a tick
// on a lit display emits one drive word, plus the blank word when the display
// duration runs out. Write configuration only while the block is idle.
module seven_segment_scan_driver_unit #(
  parameter int unsigned DIGITS = ssd_pkg::DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [ssd_pkg::TPS_W-1:0]     cfg_data_i,
  // Input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ssd_pkg::IN_DATA_W-1:0] s_axis_tdata,  // value[23:0], dots[29:24],
                                                       // duration_seconds[37:30], zero pad
  input  logic                          s_axis_tuser,  // kind
  // Result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ssd_pkg::WORD_W-1:0]    m_axis_tdata,  // drive_word[15:0]
  output logic                          m_axis_tuser,  // finished
  output logic                          m_axis_tlast   // last
);
  import ssd_pkg::*;

  logic             time_format_q;
  logic [TPS_W-1:0] tps_q;
  logic             room;
  conv_t            conv;
  push_t            push;
  cfg_reg_e         cfg_reg;

  assign cfg_ready_o   = 1'b1;
  assign cfg_reg       = cfg_reg_e'(cfg_index_i);
  assign s_axis_tready = room;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_format_q <= TIME_FORMAT_RST;
      tps_q         <= TPS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg)
        REG_TIME_FORMAT:      time_format_q <= cfg_data_i[0];
        REG_TICKS_PER_SECOND: tps_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ssd_conv u_conv (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (room),
    .in_valid_i    (s_axis_tvalid),
    .kind_i        (kind_e'(s_axis_tuser)),
    .value_i       (s_axis_tdata[VALUE_W-1:0]),
    .dots_i        (s_axis_tdata[VALUE_W +: DOTS_W]),
    .dur_i         (s_axis_tdata[VALUE_W+DOTS_W +: DUR_W]),
    .time_format_i (time_format_q),
    .tps_i         (tps_q),
    .out_o         (conv)
  );

  ssd_scan #(
    .DIGITS (DIGITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (room),
    .conv_i (conv),
    .push_o (push)
  );

  ssd_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .room_o        (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- rtl/core/ssd_checker.sv -----
// ----------------------------------------------------------------------------
// ssd_checker: port-level checks of the scan driver
// Watches the result stream for well-formed drive words and blank words.
// ----------------------------------------------------------------------------
module ssd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [ssd_pkg::WORD_W-1:0] m_axis_tdata,
  input logic                       m_axis_tuser,
  input logic                       m_axis_tlast
);

  // The closing word is blank and ends the tick's results
  a_blank_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && m_axis_tlast)
    else $error("closing item is not a blank last word");

  // A drive word selects exactly one digit
  a_one_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> $countones(m_axis_tdata[15:8]) == 7)
    else $error("drive word does not select exactly one digit");

  // A drive word that is not last is followed by the blank word
  a_blank_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser)
    else $error("blank word missing after closing drive word");

  // Hold a stalled item
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled item changed");

endmodule

bind seven_segment_scan_driver_unit ssd_checker u_ssd_checker (.*);

// ----- verif/ssd_scan_checker.sv -----
// ----------------------------------------------------------------------------
// ssd_scan_checker: scoreboard for the seven-segment scan driver
// Watches the configuration, input and result channels, keeps its own copy
// of the display state, predicts the drive words of every accepted item and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module ssd_scan_checker #(
  parameter int unsigned DIGITS = ssd_pkg::DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic                          cfg_index_i,
  input  logic [ssd_pkg::TPS_W-1:0]     cfg_data_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [ssd_pkg::IN_DATA_W-1:0] s_tdata_i,  // value, dots, duration_seconds
  input  logic                          s_tuser_i,  // kind
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [ssd_pkg::WORD_W-1:0]    m_tdata_i,  // drive_word
  input  logic                          m_tuser_i,  // finished
  input  logic                          m_tlast_i,  // last
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);
  import ssd_pkg::*;

  // Segment patterns of digits 0..9, digit 0 in the lowest slot
  localparam logic [9:0][6:0] SEG_LUT = {
    7'h6F, 7'h7F, 7'h27, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  // Shadow of the configuration registers
  logic             time_fmt;
  logic [TPS_W-1:0] tps;

  // Shadow of the display state
  logic [3:0]         digit_q [DIGITS_MAX];
  logic [DOTS_W-1:0]  dot_q;
  int unsigned        scan_pos;
  logic [LIMIT_W-1:0] tick_cnt;
  logic [LIMIT_W-1:0] tick_lim;
  logic               lit;

  // Drive words still to come, oldest first
  res_t drive_word_q [$];
  int   fails;
  int   checked;

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    res_t              exp_r;
    logic [WORD_W-1:0] word;
    logic [7:0]        sel;
    logic              dot;
    logic              done;
    logic [31:0]       prod;
    int                v;
    int                n;
    if (!rst_ni) begin
      time_fmt = TIME_FORMAT_RST;
      tps      = TPS_RST;
      for (int i = 0; i < DIGITS_MAX; i++) digit_q[i] = 4'd0;
      dot_q    = '0;
      scan_pos = 0;
      tick_cnt = '0;
      tick_lim = '0;
      lit      = 1'b0;
      drive_word_q.delete();
      fails    = 0;
      checked  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // Compare an accepted result with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        if (drive_word_q.size() == 0) begin
          $error("unexpected result: drive_word %04h finished %0b last %0b",
                 m_tdata_i, m_tuser_i, m_tlast_i);
          fails++;
        end else begin
          exp_r = drive_word_q.pop_front();
          checked++;
          if (m_tdata_i !== exp_r.word) begin
            $error("drive_word: expected %04h, got %04h", exp_r.word, m_tdata_i);
            fails++;
          end
          if (m_tuser_i !== exp_r.fin) begin
            $error("finished: expected %0b, got %0b", exp_r.fin, m_tuser_i);
            fails++;
          end
          if (m_tlast_i !== exp_r.last) begin
            $error("last: expected %0b, got %0b", exp_r.last, m_tlast_i);
            fails++;
          end
        end
      end

      // Track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_reg_e'(cfg_index_i) == REG_TIME_FORMAT) time_fmt = cfg_data_i[0];
        else tps = cfg_data_i;
      end

      // Predict the effect of an accepted input item
      if (s_tvalid_i && s_tready_i) begin
        if (kind_e'(s_tuser_i) == KIND_LOAD) begin
          // Latch digits, dots and limit, restart the scan at digit 0
          v = int'(s_tdata_i[VALUE_W-1:0]);
          if (time_fmt) n = (v / 3600) * 10000 + ((v % 3600) / 60) * 100 + v % 60;
          else n = v;
          for (int i = DIGITS - 1; i >= 0; i--) begin
            digit_q[i] = 4'(n % 10);
            n = n / 10;
          end
          dot_q    = s_tdata_i[VALUE_W +: DOTS_W];
          prod     = 32'(s_tdata_i[VALUE_W+DOTS_W +: DUR_W]) * 32'(tps);
          tick_lim = prod[LIMIT_W-1:0];
          tick_cnt = '0;
          scan_pos = 0;
          lit      = 1'b1;
        end else if (lit) begin
          // Drive the current digit, then advance the scan
          sel  = 8'hFF & ~(8'h01 << scan_pos);
          dot  = (scan_pos < DOTS_W) ? dot_q[scan_pos] : 1'b0;
          word = {sel, dot, SEG_LUT[digit_q[scan_pos]]};
          scan_pos = (scan_pos + 1 >= DIGITS) ? 0 : scan_pos + 1;
          tick_cnt = tick_cnt + 1'b1;
          done     = tick_cnt > tick_lim;
          drive_word_q.push_back('{word: word, fin: 1'b0, last: !done});
          if (done) begin
            drive_word_q.push_back('{word: '0, fin: 1'b1, last: 1'b1});
            lit = 1'b0;
          end
        end
      end

      fail_count_o <= fails;
      pending_o    <= drive_word_q.size();
      checked_o    <= checked;
    end
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench top of the seven-segment scan driver
// Drives directed and random load/tick items and register settings with
// random idling on both sides, a long output hold-off and a full drain, and
// reports the verdict from the scoreboard's failure and pending counts.
// ----------------------------------------------------------------------------
module tb;
  import ssd_pkg::*;

  localparam int ITEM_TARGET   = 1300;
  localparam int CALM_TAIL     = 150;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 30;
  localparam int LONG_HOLD     = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_AT       = 500;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_index_i   = 1'b0;
  logic [TPS_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata  = '0;  // value[23:0], dots[29:24], duration[37:30]
  logic                 s_axis_tuser  = 1'b0;  // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [WORD_W-1:0]    m_axis_tdata;  // drive_word
  logic                 m_axis_tuser;  // finished
  logic                 m_axis_tlast;  // last

  int   fail_count;
  int   pending;
  int   checked;
  int   item_count   = 0;
  int   load_count   = 0;
  int   write_count  = 0;
  int   set_count    = 0;
  int   quiet_cycles = 0;
  logic calm         = 1'b0;
  logic hold_req     = 1'b0;

  always #2 clk_i = ~clk_i;

  seven_segment_scan_driver_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ssd_scan_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Offer one item, with an optional random gap first, and wait for acceptance
  task automatic send_item(input kind_e kind, input logic [VALUE_W-1:0] value,
                           input logic [DOTS_W-1:0] dots, input logic [DUR_W-1:0] dur,
                           input bit counted);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, dur, dots, value};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (counted) item_count++;
    if (kind == KIND_LOAD) load_count++;
    calm = (item_count >= ITEM_TARGET - CALM_TAIL);
  endtask

  // Tick with random content in the unused fields
  task automatic send_tick(input bit counted);
    send_item(KIND_TICK, VALUE_W'($urandom), DOTS_W'($urandom), DUR_W'($urandom), counted);
  endtask

  // Stop offering, wait for every predicted result and the pipe to empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Present one register write and wait for acceptance
  task automatic write_reg(input cfg_reg_e idx, input logic [TPS_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    write_count++;
  endtask

  // Idle the block, then write both registers
  task automatic set_config(input logic tf, input logic [TPS_W-1:0] tps);
    settle();
    write_reg(REG_TIME_FORMAT, {{(TPS_W-1){1'b0}}, tf});
    write_reg(REG_TICKS_PER_SECOND, tps);
    cfg_valid_i <= 1'b0;
    set_count++;
  endtask

  // Output side: random stall bursts, one long hold-off on request
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (rst_ni && !calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // End the run when no channel moves an item for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [TPS_W-1:0] tps;
    logic             tf;
    logic [DUR_W-1:0] dur;
    bit               hold_started;
    int               lim;
    int               ticks;
    int               pick;
    hold_started = 1'b0;

    // Hold reset, then release it
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: time mode, 1000 ticks per second
    send_tick(1'b0);                                  // idle tick, no result
    send_item(KIND_LOAD, 24'd0, 6'h00, 8'd0, 1'b1);   // zero duration
    send_tick(1'b1);
    send_item(KIND_LOAD, 24'hFFFFFF, 6'h3F, 8'd255, 1'b1);  // unbounded hours
    repeat (7) send_tick(1'b1);                       // wrap of the scan
    send_item(KIND_LOAD, 24'd86399, 6'h15, 8'd1, 1'b1);
    repeat (3) send_tick(1'b1);

    // Raw mode with zero ticks per second: limit is zero
    set_config(1'b0, 16'd0);
    send_item(KIND_LOAD, 24'd123456, 6'h2A, 8'd200, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_item(KIND_LOAD, 24'hFFFFFF, 6'h00, 8'd0, 1'b1);  // value wraps at six digits
    send_tick(1'b1);
    send_item(KIND_LOAD, 24'd9876543, 6'h3F, 8'd1, 1'b1);
    send_tick(1'b1);

    // Largest tick rate and duration
    set_config(1'b0, 16'hFFFF);
    send_item(KIND_LOAD, 24'd0, 6'h00, 8'd255, 1'b1);
    send_tick(1'b1);

    // Random settings with mostly complete display runs
    while (item_count < ITEM_TARGET) begin
      if (!hold_started && item_count >= HOLD_AT) begin
        // Fill the block while the output holds off
        hold_started = 1'b1;
        set_config(1'b1, 16'd50);
        send_item(KIND_LOAD, VALUE_W'($urandom), DOTS_W'($urandom), 8'd2, 1'b1);
        hold_req <= 1'b1;
        repeat (101) send_tick(1'b1);
      end

      pick = $urandom_range(0, 9);
      tf   = 1'($urandom_range(0, 1));
      if (pick == 0) tps = 16'd0;
      else if (pick <= 5) tps = TPS_W'($urandom_range(1, 4));
      else if (pick == 6 || pick == 7) tps = TPS_W'($urandom_range(5, 60));
      else if (pick == 8) tps = 16'hFFFF;
      else tps = TPS_W'($urandom);
      set_config(tf, tps);

      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: any kind, any content
          send_item(kind_e'($urandom_range(0, 1)), VALUE_W'($urandom),
                    DOTS_W'($urandom), DUR_W'($urandom), 1'b1);
        end else begin
          if (tps <= 4)
            dur = DUR_W'((tps == 1 && $urandom_range(0, 11) == 0) ? $urandom_range(0, 255)
                                                                   : $urandom_range(0, 6));
          else if (tps <= 60)
            dur = DUR_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 3));
          else
            dur = DUR_W'($urandom_range(0, 255));
          send_item(KIND_LOAD, VALUE_W'($urandom), DOTS_W'($urandom), dur, 1'b1);
          lim = int'(dur) * int'(tps);
          if (lim <= 300) begin
            // Full run to the blank word, sometimes cut short by the next load
            if ($urandom_range(0, 4) == 0) begin
              ticks = $urandom_range(0, lim);
              repeat (ticks) send_tick(1'b1);
            end else begin
              repeat (lim + 1) send_tick(1'b1);
              repeat ($urandom_range(0, 2)) send_tick(1'b0);
            end
          end else begin
            ticks = $urandom_range(1, 30);
            repeat (ticks) send_tick(1'b1);
          end
        end
      end
    end

    // Drain and report
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d items (%0d loads) under %0d register settings, %0d writes",
             item_count, load_count, set_count + 1, write_count);
    $display("Compared %0d drive words, including one long output hold-off", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
